>>> rtl/kwl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwl_pkg
// Types, codes and character class helpers shared by the keyword lexer.
// ----------------------------------------------------------------------------
package kwl_pkg;

  localparam int CHAR_BITS      = 8;
  localparam int KW_BITS        = 48;
  localparam int CFG_INDEX_BITS = 4;
  localparam int KIND_BITS      = 3;
  localparam int QUEUE_DEPTH    = 4;

  typedef logic [CHAR_BITS-1:0] char_t;
  typedef logic [KW_BITS-1:0]   kw_word_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2
  } scan_mode_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_KEYWORD = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_SYMBOL  = 3'd3,
    KIND_UNKNOWN = 3'd4,
    KIND_END     = 3'd5
  } token_kind_t;

  // default keyword text: if, else, while, return
  function automatic kw_word_t kw_default(input int unsigned idx);
    kw_word_t w;
    unique case (idx)
      0:       w = 48'h0000_0000_6669;
      1:       w = 48'h0000_6573_6C65;
      2:       w = 48'h0065_6C69_6877;
      3:       w = 48'h6E72_7574_6572;
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic is_letter(input char_t c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_decimal(input char_t c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_blank(input char_t c);
    return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic logic is_symbol(input char_t c);
    return c == "+" || c == "-" || c == "*" || c == "/" ||
           c == "=" || c == ";" || c == "(" || c == ")";
  endfunction

endpackage

>>> rtl/kwl_keyword_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwl_keyword_bank
// Keyword registers with their write port and the parallel text compare.
// ----------------------------------------------------------------------------
module kwl_keyword_bank #(
  parameter int KEYWORD_COUNT = 4,
  parameter int KEYWORD_CHARS = 6
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [kwl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  kwl_pkg::kw_word_t                  cfg_data,
  input  logic [8*KEYWORD_CHARS-1:0]         prefix,
  output logic                               hit
);
  import kwl_pkg::*;

  localparam int PW = 8 * KEYWORD_CHARS;
  localparam int CW = (PW > KW_BITS) ? PW : KW_BITS;

  kw_word_t kw_r [KEYWORD_COUNT];
  logic [CW-1:0] pre_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEYWORD_COUNT; i++) begin
        kw_r[i] <= kw_default(i);
      end
    end else if (cfg_valid) begin
      // writes beyond the register list fall through
      for (int i = 0; i < KEYWORD_COUNT; i++) begin
        if (cfg_index == CFG_INDEX_BITS'(i)) begin
          kw_r[i] <= cfg_data;
        end
      end
    end
  end

  assign pre_ext = CW'(prefix);

  always_comb begin
    logic [CW-1:0] kw_ext;
    hit = 1'b0;
    for (int i = 0; i < KEYWORD_COUNT; i++) begin
      kw_ext = CW'(kw_r[i]);
      if (kw_ext[PW-1:0] == pre_ext[PW-1:0]) begin
        hit = 1'b1;
      end
    end
  end

endmodule

>>> rtl/kwl_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwl_scanner
// Per-byte scan state and token result generation, zero to two results a byte.
// ----------------------------------------------------------------------------
module kwl_scanner #(
  parameter int KEYWORD_CHARS = 6,
  parameter int POSITION_BITS = 32,
  parameter int LENGTH_BITS   = 16,
  parameter int RW            = 3 + 32 + 16 + 9
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_fire,
  input  kwl_pkg::char_t             char_in,
  input  logic                       kw_hit,
  output logic [8*KEYWORD_CHARS-1:0] prefix,
  output logic [1:0]                 wr_cnt,
  output logic [RW-1:0]              res_a,
  output logic [RW-1:0]              res_b
);
  import kwl_pkg::*;

  localparam int PW = 8 * KEYWORD_CHARS;

  scan_mode_t               mode_r, mode_nxt;
  logic [PW-1:0]            prefix_r, prefix_nxt;
  logic [LENGTH_BITS-1:0]   run_len_r, run_len_nxt;
  logic [POSITION_BITS-1:0] run_start_r, run_start_nxt;
  logic [POSITION_BITS-1:0] byte_pos_r, byte_pos_nxt;

  logic        c_letter, c_digit, c_blank;
  logic        cont, flush, new_res;
  token_kind_t flush_kind, new_kind;
  logic [LENGTH_BITS-1:0] run_len_inc;

  assign c_letter = is_letter(char_in);
  assign c_digit  = is_decimal(char_in);
  assign c_blank  = is_blank(char_in);
  assign prefix   = prefix_r;

  assign run_len_inc = (run_len_r == '1) ? run_len_r : run_len_r + 1'b1;

  // next state
  always_comb begin
    cont = 1'b0;
    unique case (mode_r)
      MODE_IDENT:  cont = c_letter || c_digit;
      MODE_NUMBER: cont = c_digit;
      default:     cont = 1'b0;
    endcase

    mode_nxt      = mode_r;
    prefix_nxt    = prefix_r;
    run_len_nxt   = run_len_r;
    run_start_nxt = run_start_r;
    byte_pos_nxt  = byte_pos_r + 1'b1;

    if (cont) begin
      run_len_nxt = run_len_inc;
      if (mode_r == MODE_IDENT) begin
        for (int i = 0; i < KEYWORD_CHARS; i++) begin
          if (run_len_r == LENGTH_BITS'(i)) begin
            prefix_nxt[8*i +: 8] = prefix_r[8*i +: 8] | char_in;
          end
        end
      end
    end else begin
      mode_nxt = MODE_IDLE;
      if (char_in == '0) begin
        byte_pos_nxt = '0;
      end else if (c_letter) begin
        mode_nxt      = MODE_IDENT;
        run_start_nxt = byte_pos_r;
        run_len_nxt   = LENGTH_BITS'(1);
        prefix_nxt    = PW'(char_in);
      end else if (c_digit) begin
        mode_nxt      = MODE_NUMBER;
        run_start_nxt = byte_pos_r;
        run_len_nxt   = LENGTH_BITS'(1);
        prefix_nxt    = '0;
      end
    end
  end

  // results
  always_comb begin
    flush      = 1'b0;
    flush_kind = KIND_IDENT;
    new_res    = 1'b0;
    new_kind   = KIND_UNKNOWN;

    if (!cont) begin
      if (mode_r == MODE_IDENT) begin
        flush      = 1'b1;
        // keyword only while the whole text fits in the prefix
        flush_kind = (kw_hit && run_len_r <= LENGTH_BITS'(KEYWORD_CHARS)) ?
                     KIND_KEYWORD : KIND_IDENT;
      end else if (mode_r == MODE_NUMBER) begin
        flush      = 1'b1;
        flush_kind = KIND_NUMBER;
      end

      if (char_in == '0) begin
        new_res  = 1'b1;
        new_kind = KIND_END;
      end else if (!c_blank && !c_letter && !c_digit) begin
        new_res  = 1'b1;
        new_kind = is_symbol(char_in) ? KIND_SYMBOL : KIND_UNKNOWN;
      end
    end
  end

  always_comb begin
    logic [RW-1:0] flush_word, new_word;
    logic          new_last;
    new_last   = 1'b1;
    flush_word = {flush_kind, run_start_r, run_len_r, CHAR_BITS'(0), !new_res};
    new_word   = {new_kind, byte_pos_r,
                  (new_kind == KIND_END) ? LENGTH_BITS'(0) : LENGTH_BITS'(1),
                  (new_kind == KIND_END) ? CHAR_BITS'(0) : char_in, new_last};
    res_a  = flush ? flush_word : new_word;
    res_b  = new_word;
    wr_cnt = in_fire ? (2'(flush) + 2'(new_res)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      prefix_r    <= '0;
      run_len_r   <= '0;
      run_start_r <= '0;
      byte_pos_r  <= '0;
    end else if (in_fire) begin
      mode_r      <= mode_nxt;
      prefix_r    <= prefix_nxt;
      run_len_r   <= run_len_nxt;
      run_start_r <= run_start_nxt;
      byte_pos_r  <= byte_pos_nxt;
    end
  end

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && char_in == '0 |=> byte_pos_r == '0 && mode_r == MODE_IDLE)
    else $error("end of text did not restart the scan");

  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != MODE_IDLE |-> run_len_r != '0)
    else $error("open run with zero length");

  a_two_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    wr_cnt == 2'd2 |-> mode_r != MODE_IDLE)
    else $error("two results without a pending run");

endmodule

>>> rtl/kwl_result_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwl_result_queue
// Small result queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module kwl_result_queue #(
  parameter int RW = 60
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    wr_cnt,
  input  logic [RW-1:0] wr_a,
  input  logic [RW-1:0] wr_b,
  output logic          full2,
  output logic          rd_valid,
  input  logic          rd_stall,
  output logic [RW-1:0] rd_data
);
  import kwl_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH;
  localparam int PTR   = $clog2(DEPTH);
  localparam int CNT   = $clog2(DEPTH + 1);

  logic [RW-1:0]  mem_r [DEPTH];
  logic [PTR-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_p1, rd_ptr_r, rd_ptr_nxt;
  logic [CNT-1:0] count_r, count_nxt;
  logic           rd_fire;

  assign rd_valid  = count_r != '0;
  assign rd_fire   = rd_valid && !rd_stall;
  assign rd_data   = mem_r[rd_ptr_r];
  // room for two more results is needed before a byte is taken
  assign full2     = count_r > CNT'(DEPTH - 2);
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR'(wr_cnt);
    rd_ptr_nxt = rd_fire ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CNT'(wr_cnt) - CNT'(rd_fire);
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= wr_a;
    end
    if (wr_cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= wr_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_cnt != 2'd0 |-> (CNT + 1)'(count_r) + (CNT + 1)'(wr_cnt) <= (CNT + 1)'(DEPTH))
    else $error("result queue overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != CNT'(DEPTH) |-> PTR'(wr_ptr_r - rd_ptr_r) == PTR'(count_r))
    else $error("queue pointers disagree with count");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    rd_fire && wr_cnt == 2'd0 |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count wrong after a read");

endmodule

>>> rtl/keyword_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_lexer
// Streaming tokenizer: one text byte per transaction, identifiers, keywords,
// numbers, symbols, unknown bytes and end of text, with source positions.
//
//   channel  direction  handshake            payload
//   in_      sink       in_valid / in_stall  in_char_in
//   out_     source     out_valid/out_stall  kind, start, length, char, last
//   cfg_     sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; its results are written
// to a four-entry queue in the same cycle, and from an empty queue the first
// is offered in the next cycle. A byte that ends a run can give two results,
// but a byte that gave none always comes between two such bytes, so one queue
// read per cycle keeps up with one byte a cycle. in_stall rises when the queue
// has fewer than two free entries, which happens only while out_stall holds
// results back. Synchronous reset clears the scan state and the queue and
// loads the default keywords; cfg_ready is always high.
// ----------------------------------------------------------------------------
module keyword_lexer #(
  parameter int KEYWORD_COUNT = 4,
  parameter int KEYWORD_CHARS = 6,
  parameter int POSITION_BITS = 32,
  parameter int LENGTH_BITS   = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  kwl_pkg::char_t                     in_char_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [kwl_pkg::KIND_BITS-1:0]      out_token_kind,
  output logic [POSITION_BITS-1:0]           out_token_start,
  output logic [LENGTH_BITS-1:0]             out_token_length,
  output kwl_pkg::char_t                     out_char_value,
  output logic                               out_last_of_run,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [kwl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  kwl_pkg::kw_word_t                  cfg_data
);
  import kwl_pkg::*;

  localparam int RW = KIND_BITS + POSITION_BITS + LENGTH_BITS + CHAR_BITS + 1;

  logic                       in_fire, full2, kw_hit;
  logic [8*KEYWORD_CHARS-1:0] prefix;
  logic [1:0]                 wr_cnt;
  logic [RW-1:0]              res_a, res_b, rd_data;

  assign in_stall  = full2;
  assign in_fire   = in_valid && !full2;
  assign cfg_ready = 1'b1;

  kwl_keyword_bank #(
    .KEYWORD_COUNT (KEYWORD_COUNT),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .prefix    (prefix),
    .hit       (kw_hit)
  );

  kwl_scanner #(
    .KEYWORD_CHARS (KEYWORD_CHARS),
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS),
    .RW            (RW)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .char_in (in_char_in),
    .kw_hit  (kw_hit),
    .prefix  (prefix),
    .wr_cnt  (wr_cnt),
    .res_a   (res_a),
    .res_b   (res_b)
  );

  kwl_result_queue #(
    .RW (RW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cnt   (wr_cnt),
    .wr_a     (res_a),
    .wr_b     (res_b),
    .full2    (full2),
    .rd_valid (out_valid),
    .rd_stall (out_stall),
    .rd_data  (rd_data)
  );

  assign {out_token_kind, out_token_start, out_token_length,
          out_char_value, out_last_of_run} = rd_data;

endmodule
